// File: rtl/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg
// Shared types and constants of the trajectory extrapolator.
// ----------------------------------------------------------------------------
`default_nettype none
package kte_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [1:0] CFG_STEP_MS    = 2'd1;

    localparam logic [6:0] STEP_COUNT_RST = 7'd25;
    localparam logic [9:0] STEP_MS_RST    = 10'd20;

    // CORDIC
    localparam int              CORDIC_ITERS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // reciprocals for the constant divides (floor(2^41/15625), floor(2^29/125))
    localparam logic [27:0] RECIP_DIST = 28'd140737488;
    localparam logic [22:0] RECIP_SPD  = 23'd4294967;

    localparam int OUT_DEPTH = 16;
    localparam int DESC_DEPTH = 2;
    localparam int PIPE_STAGES = 9;

    // atan(2^-k) in 2^-32 turn units
    function automatic logic signed [33:0] atan_turns(input logic [4:0] k);
        logic signed [33:0] v;
        case (k)
            5'd0:  v = 34'sh20000000;
            5'd1:  v = 34'sh12E4051E;
            5'd2:  v = 34'sh09FB385B;
            5'd3:  v = 34'sh051111D4;
            5'd4:  v = 34'sh028B0D43;
            5'd5:  v = 34'sh0145D7E1;
            5'd6:  v = 34'sh00A2F61E;
            5'd7:  v = 34'sh00517C55;
            5'd8:  v = 34'sh0028BE53;
            5'd9:  v = 34'sh00145F2F;
            5'd10: v = 34'sh000A2F98;
            5'd11: v = 34'sh000517CC;
            5'd12: v = 34'sh00028BE6;
            5'd13: v = 34'sh000145F3;
            5'd14: v = 34'sh0000A2FA;
            5'd15: v = 34'sh0000517D;
            5'd16: v = 34'sh000028BE;
            5'd17: v = 34'sh0000145F;
            5'd18: v = 34'sh00000A30;
            5'd19: v = 34'sh00000518;
            5'd20: v = 34'sh0000028C;
            5'd21: v = 34'sh00000146;
            5'd22: v = 34'sh000000A3;
            5'd23: v = 34'sh00000051;
            5'd24: v = 34'sh00000029;
            5'd25: v = 34'sh00000014;
            5'd26: v = 34'sh0000000A;
            5'd27: v = 34'sh00000005;
            5'd28: v = 34'sh00000003;
            5'd29: v = 34'sh00000001;
            default: v = 34'sh0;
        endcase
        return v;
    endfunction

    // vehicle state plus its heading unit vector
    typedef struct packed {
        logic [15:0]        tag;
        logic [31:0]        t0;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [15:0]        v;
        logic signed [15:0] a;
        logic [15:0]        hd;
        logic signed [15:0] c;
        logic signed [15:0] s;
    } t_desc;

    // one point moving through the back pipeline
    typedef struct packed {
        t_desc              d;
        logic [6:0]         i;
        logic               last;
        logic [16:0]        tt_ms;
        logic [31:0]        pt;
        logic [32:0]        vt;
        logic [33:0]        tsq;
        logic signed [33:0] at;
        logic [43:0]        vt2k;
        logic signed [50:0] att;
        logic signed [34:0] sn;
        logic [40:0]        m;
        logic [28:0]        m2;
        logic [47:0]        phi;
        logic [48:0]        plo;
        logic [51:0]        sp;
        logic [26:0]        qe;
        logic [21:0]        qs;
        logic [15:0]        r;
        logic [7:0]         rs;
        logic [26:0]        travel;
        logic [15:0]        spd;
        logic [41:0]        pc;
        logic [41:0]        ps;
    } t_pipe;

    typedef struct packed {
        logic [15:0] vehicle;
        logic [6:0]  step;
        logic [31:0] time_ms;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] speed;
        logic [15:0] heading;
        logic [15:0] accel;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/kte_fifo.sv
// ----------------------------------------------------------------------------
// kte_fifo
// Small register queue with a first-word view of the oldest item.
// ----------------------------------------------------------------------------
`default_nettype none
module kte_fifo #(
    parameter type t_item = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wr,
    input  t_item i_wdata,
    output logic  o_full,
    input  wire   i_rd,
    output t_item o_rdata,
    output logic  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end
endmodule
`default_nettype wire

// File: rtl/kte_front.sv
// ----------------------------------------------------------------------------
// kte_front
// Input buffer and iterative CORDIC: turns a vehicle state into a descriptor
// carrying the heading cosine and sine in Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none
module kte_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  kte_pkg::t_desc i_item,
    output logic          o_full,
    output logic          o_q_wr,
    output kte_pkg::t_desc o_q_data,
    input  wire           i_q_full
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state              r_state;
    logic                r_ib_valid;
    kte_pkg::t_desc      r_ib;
    kte_pkg::t_desc      r_d;
    logic signed [33:0]  r_x;
    logic signed [33:0]  r_y;
    logic signed [33:0]  r_z;
    logic [4:0]          r_k;
    logic                take;
    logic signed [33:0]  dx;
    logic signed [33:0]  dy;
    logic signed [33:0]  at;
    logic signed [33:0]  xr;
    logic signed [33:0]  yr;
    logic signed [15:0]  c0;
    logic signed [15:0]  s0;
    logic signed [15:0]  c_q;
    logic signed [15:0]  s_q;

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        logic signed [15:0] o;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            o = 16'sd32767;
        end else if (r < -34'sd32767) begin
            o = -16'sd32767;
        end else begin
            o = 16'(r);
        end
        return o;
    endfunction

    assign o_full = r_ib_valid;
    assign take   = (r_state == ST_IDLE) && r_ib_valid;
    assign o_q_wr = (r_state == ST_DONE) && !i_q_full;

    // one rotation step
    assign dx = r_y >>> r_k;
    assign dy = r_x >>> r_k;
    assign at = kte_pkg::atan_turns(r_k);

    // rounding and quadrant fold
    assign xr = r_x;
    assign yr = r_y;
    assign c0 = to_q15(xr);
    assign s0 = to_q15(yr);
    always_comb begin
        case (r_d.hd[15:14])
            2'd0: begin c_q = c0;  s_q = s0;  end
            2'd1: begin c_q = -s0; s_q = c0;  end
            2'd2: begin c_q = -c0; s_q = -s0; end
            default: begin c_q = s0; s_q = -c0; end
        endcase
    end

    always_comb begin
        o_q_data   = r_d;
        o_q_data.c = c_q;
        o_q_data.s = s_q;
    end

    // input buffer
    always_ff @(posedge i_clk) begin
        if (i_push && !r_ib_valid) begin
            r_ib <= i_item;
        end
    end

    // sequencer and CORDIC datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ib_valid <= 1'b0;
            r_k        <= '0;
        end else begin
            if (take) begin
                r_ib_valid <= 1'b0;
            end else if (i_push) begin
                r_ib_valid <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_d     <= r_ib;
                        r_x     <= kte_pkg::CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= $signed({4'b0, r_ib.hd[13:0], 16'b0});
                        r_k     <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'(kte_pkg::CORDIC_ITERS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!i_q_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/kte_back.sv
// ----------------------------------------------------------------------------
// kte_back
// Point generator and arithmetic pipeline: one predicted point per cycle,
// throttled by credits against the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module kte_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire [6:0]       i_n,
    input  wire [9:0]       i_step_ms,
    input  wire             i_q_valid,
    input  kte_pkg::t_desc  i_q_data,
    output logic            o_q_rd,
    input  wire             i_pop,
    output logic            o_res_wr,
    output kte_pkg::t_result o_res
);
    localparam int NS = kte_pkg::PIPE_STAGES;
    localparam int UW = $clog2(kte_pkg::OUT_DEPTH + 1);

    kte_pkg::t_desc  r_d;
    logic            r_busy;
    logic [6:0]      r_i;
    logic [6:0]      r_n;
    logic [16:0]     r_t;
    logic [UW-1:0]   r_used;
    kte_pkg::t_pipe  r_p [NS];
    logic [NS-1:0]   r_v;
    kte_pkg::t_pipe  n_p [NS];
    logic            issue;
    logic            last;
    logic            load;

    logic [32:0]        pt_sum;
    logic signed [51:0] dn;
    logic [69:0]        prod;
    logic [41:0]        rem;
    logic [29:0]        rems;
    logic [22:0]        spd_q;
    logic [15:0]        c_abs;
    logic [15:0]        s_abs;
    logic [26:0]        mag_x;
    logic [26:0]        mag_y;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;

    assign last   = (r_i == r_n);
    assign issue  = r_busy && (r_used < UW'(kte_pkg::OUT_DEPTH));
    assign load   = i_q_valid && (!r_busy || (issue && last));
    assign o_q_rd = load;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] o;
        if (v > 34'sd2147483647) begin
            o = 32'h7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            o = 32'h80000000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    // point sequencer and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_used <= '0;
            r_v    <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (issue && last) begin
                r_busy <= 1'b0;
            end
            r_used <= r_used + UW'(issue) - UW'(i_pop);
            r_v    <= {r_v[NS-2:0], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_d <= i_q_data;
            r_i <= 7'd1;
            r_t <= 17'(i_step_ms);
            r_n <= i_n;
        end else if (issue) begin
            r_i <= r_i + 1'b1;
            r_t <= r_t + 17'(i_step_ms);
        end
        for (int k = 0; k < NS; k++) begin
            r_p[k] <= n_p[k];
        end
    end

    // pipeline stages
    always_comb begin
        pt_sum = '0;
        dn     = '0;
        prod   = '0;
        rem    = '0;
        rems   = '0;
        spd_q  = '0;
        c_abs  = '0;
        s_abs  = '0;

        // stage 0: new point
        n_p[0]       = r_p[0];
        n_p[0].d     = r_d;
        n_p[0].i     = r_i;
        n_p[0].last  = last;
        n_p[0].tt_ms = r_t;

        // stage 1: first products, timestamp
        n_p[1]     = r_p[0];
        n_p[1].vt  = 33'(r_p[0].d.v) * 33'(r_p[0].tt_ms);
        n_p[1].tsq = 34'(r_p[0].tt_ms) * 34'(r_p[0].tt_ms);
        n_p[1].at  = 34'(r_p[0].d.a * $signed({1'b0, r_p[0].tt_ms}));
        pt_sum     = 33'(r_p[0].d.t0) + 33'(r_p[0].tt_ms);
        n_p[1].pt  = pt_sum[32] ? 32'hFFFFFFFF : pt_sum[31:0];

        // stage 2: distance and speed numerators
        n_p[2]      = r_p[1];
        n_p[2].vt2k = 44'(r_p[1].vt) * 44'd2000;
        n_p[2].att  = 51'(r_p[1].d.a * $signed({1'b0, r_p[1].tsq}));
        n_p[2].sn   = 35'($signed({1'b0, 26'(r_p[1].d.v) * 26'd1000})) + 35'(r_p[1].at);

        // stage 3: clamp at zero, round, strip power-of-two factors
        n_p[3] = r_p[2];
        dn     = 52'($signed({1'b0, r_p[2].vt2k})) + 52'(r_p[2].att);
        n_p[3].m  = (dn > 52'sd0) ? 41'((dn + 52'sd1000000) >>> 7) : '0;
        n_p[3].m2 = (r_p[2].sn > 35'sd0) ? 29'((r_p[2].sn + 35'sd500) >>> 3) : '0;

        // stage 4: reciprocal partial products
        n_p[4]     = r_p[3];
        n_p[4].phi = 48'(r_p[3].m[40:21]) * 48'(kte_pkg::RECIP_DIST);
        n_p[4].plo = 49'(r_p[3].m[20:0]) * 49'(kte_pkg::RECIP_DIST);
        n_p[4].sp  = 52'(r_p[3].m2) * 52'(kte_pkg::RECIP_SPD);

        // stage 5: quotient estimates
        n_p[5]    = r_p[4];
        prod      = (70'(r_p[4].phi) << 21) + 70'(r_p[4].plo);
        n_p[5].qe = 27'(prod >> 41);
        n_p[5].qs = 22'(r_p[4].sp >> 29);

        // stage 6: remainders
        n_p[6]    = r_p[5];
        rem       = 42'(r_p[5].m) - 42'(r_p[5].qe) * 42'd15625;
        rems      = 30'(r_p[5].m2) - 30'(r_p[5].qs) * 30'd125;
        n_p[6].r  = rem[15:0];
        n_p[6].rs = rems[7:0];

        // stage 7: one-step correction, speed saturation
        n_p[7]        = r_p[6];
        n_p[7].travel = r_p[6].qe + 27'(r_p[6].r >= 16'd15625);
        spd_q         = 23'(r_p[6].qs) + 23'(r_p[6].rs >= 8'd125);
        n_p[7].spd    = (spd_q > 23'd65535) ? 16'hFFFF : spd_q[15:0];

        // stage 8: projection products
        n_p[8]    = r_p[7];
        c_abs     = r_p[7].d.c[15] ? 16'(-r_p[7].d.c) : 16'(r_p[7].d.c);
        s_abs     = r_p[7].d.s[15] ? 16'(-r_p[7].d.s) : 16'(r_p[7].d.s);
        n_p[8].pc = 42'(r_p[7].travel) * 42'(c_abs[14:0]);
        n_p[8].ps = 42'(r_p[7].travel) * 42'(s_abs[14:0]);
    end

    // final rounding and saturating position add
    assign mag_x = 27'((r_p[NS-1].pc + 42'd16384) >> 15);
    assign mag_y = 27'((r_p[NS-1].ps + 42'd16384) >> 15);
    always_comb begin
        sum_x = 34'($signed(r_p[NS-1].d.x));
        sum_y = 34'($signed(r_p[NS-1].d.y));
        if (r_p[NS-1].d.c[15]) begin
            sum_x = sum_x - 34'(mag_x);
        end else begin
            sum_x = sum_x + 34'(mag_x);
        end
        if (r_p[NS-1].d.s[15]) begin
            sum_y = sum_y - 34'(mag_y);
        end else begin
            sum_y = sum_y + 34'(mag_y);
        end
    end

    assign o_res_wr      = r_v[NS-1];
    assign o_res.vehicle = r_p[NS-1].d.tag;
    assign o_res.step    = r_p[NS-1].i;
    assign o_res.time_ms = r_p[NS-1].pt;
    assign o_res.x       = sat32(sum_x);
    assign o_res.y       = sat32(sum_y);
    assign o_res.speed   = r_p[NS-1].spd;
    assign o_res.heading = r_p[NS-1].d.hd;
    assign o_res.accel   = r_p[NS-1].d.a;
    assign o_res.last    = r_p[NS-1].last;
endmodule
`default_nettype wire

// File: rtl/kinematic_trajectory_extrapolator.sv
// ----------------------------------------------------------------------------
// kinematic_trajectory_extrapolator
// Constant-acceleration prediction of step_count points per vehicle state.
// ----------------------------------------------------------------------------
// Path from an accepted item to its first point: input buffer, 30 CORDIC
// iterations, descriptor queue, 9-stage point pipeline.
// The iterative CORDIC limits how often a new item can start; the back pipeline
// emits one point per cycle while the result queue has credit.
// Reset (synchronous, active low) empties all queues and loads step_count 25,
// step_ms 20.
`default_nettype none
module kinematic_trajectory_extrapolator #(
    parameter int MAX_STEPS = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire        [1:0]  i_cfg_idx,
    input  wire        [9:0]  i_cfg_data,
    input  wire               push,
    output logic              full,
    input  wire        [15:0] i_vehicle_tag,
    input  wire        [31:0] i_time_ms,
    input  wire signed [31:0] i_x_pos,
    input  wire signed [31:0] i_y_pos,
    input  wire        [15:0] i_speed_in,
    input  wire signed [15:0] i_accel_in,
    input  wire        [15:0] i_heading_in,
    output logic              empty,
    input  wire               pop,
    output logic       [15:0] o_vehicle_out,
    output logic       [6:0]  o_step_number,
    output logic       [31:0] o_pred_time_ms,
    output logic signed [31:0] o_pred_x,
    output logic signed [31:0] o_pred_y,
    output logic       [15:0] o_pred_speed,
    output logic       [15:0] o_heading_out,
    output logic signed [15:0] o_accel_out,
    output logic              o_last_point
);
    logic [6:0]        r_step_count;
    logic [9:0]        r_step_ms;
    logic [6:0]        n_clamped;
    kte_pkg::t_desc    in_item;
    kte_pkg::t_desc    fq_wdata;
    kte_pkg::t_desc    fq_rdata;
    logic              fq_wr;
    logic              fq_full;
    logic              fq_empty;
    logic              fq_rd;
    logic              res_wr;
    logic              res_full;
    logic              pop_fire;
    kte_pkg::t_result  res_in;
    kte_pkg::t_result  res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= kte_pkg::STEP_COUNT_RST;
            r_step_ms    <= kte_pkg::STEP_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kte_pkg::CFG_STEP_COUNT: r_step_count <= i_cfg_data[6:0];
                kte_pkg::CFG_STEP_MS:    r_step_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // point count clamped to 1..MAX_STEPS
    always_comb begin
        if (r_step_count == 7'd0) begin
            n_clamped = 7'd1;
        end else if (r_step_count > 7'(MAX_STEPS)) begin
            n_clamped = 7'(MAX_STEPS);
        end else begin
            n_clamped = r_step_count;
        end
    end

    always_comb begin
        in_item.tag = i_vehicle_tag;
        in_item.t0  = i_time_ms;
        in_item.x   = i_x_pos;
        in_item.y   = i_y_pos;
        in_item.v   = i_speed_in;
        in_item.a   = i_accel_in;
        in_item.hd  = i_heading_in;
        in_item.c   = '0;
        in_item.s   = '0;
    end

    kte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (in_item),
        .o_full   (full),
        .o_q_wr   (fq_wr),
        .o_q_data (fq_wdata),
        .i_q_full (fq_full)
    );

    kte_fifo #(
        .t_item (kte_pkg::t_desc),
        .DEPTH  (kte_pkg::DESC_DEPTH)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_wdata (fq_wdata),
        .o_full  (fq_full),
        .i_rd    (fq_rd),
        .o_rdata (fq_rdata),
        .o_empty (fq_empty)
    );

    assign pop_fire = pop && !empty;

    kte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n       (n_clamped),
        .i_step_ms (r_step_ms),
        .i_q_valid (!fq_empty),
        .i_q_data  (fq_rdata),
        .o_q_rd    (fq_rd),
        .i_pop     (pop_fire),
        .o_res_wr  (res_wr),
        .o_res     (res_in)
    );

    kte_fifo #(
        .t_item (kte_pkg::t_result),
        .DEPTH  (kte_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    // credits keep the result queue from overflowing; full flag is spare
    assign o_vehicle_out  = res_out.vehicle;
    assign o_step_number  = res_out.step;
    assign o_pred_time_ms = res_out.time_ms;
    assign o_pred_x       = res_out.x;
    assign o_pred_y       = res_out.y;
    assign o_pred_speed   = res_out.speed;
    assign o_heading_out  = res_out.heading;
    assign o_accel_out    = res_out.accel;
    assign o_last_point   = res_out.last & !res_full | res_out.last;
endmodule
`default_nettype wire
